>>> rtl/core/hebp_pkg.sv
package hebp_pkg;

  // table geometry defaults
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;

  // field widths
  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;
  localparam int PCNT_W    = 3;
  localparam int MAX_BYTES = 4;

  // packed stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

>>> rtl/core/huffman_encoder_bit_packer_core.sv
// huffman encoder bit packer
// slave channel in_*: one request per beat, in_tuser carries the op
// (load table entry, encode symbol, flush), in_tdata the symbol, code word
// and code length. master channel out_*: packed bytes, earliest bit in
// bit seven, out_tlast set on the final byte a request produces.
// the code table sits in one synchronous memory read at the accept edge;
// a load writes it at its own accept edge, so a following encode of the same
// symbol reads the new entry without forwarding. an encode or flush passes
// the packing stage, which takes the table read, and then the byte register,
// which drives out_*. throughput: one request per cycle while each emits at
// most one byte and out_tready stays high; a request that emits more (up to
// four bytes) holds the byte register while they shift out one per handshake.
// reset clears the per-entry valid flags at once, so every entry reads as an
// unused (zero-length) code; no clearing pass is needed.
// a stalled receiver holds the byte register; the packing stage then waits and
// in_tready drops only once that stage holds bytes to emit and the register is full.
module huffman_encoder_bit_packer_core
  import hebp_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40]
  input  logic [OP_W-1:0]       in_tuser,  // op[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // out_byte[7:0]
  output logic                  out_tlast  // last_of_run
);

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int ALN_W   = ACC_W + 1;
  localparam int EMIT_W  = MAX_BYTES * BYTE_W;
  localparam int ECNT_W  = $clog2(MAX_BYTES + 1);

  // unpack request
  logic [SYM_W-1:0]  in_sym;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  in_len_sat;
  logic              in_acc;
  logic              in_hit;
  logic [IDX_W-1:0]  in_idx;

  assign in_sym  = in_tdata[SYM_W-1:0];
  assign in_code = in_tdata[SYM_W +: CODE_W];
  assign in_len  = in_tdata[SYM_W+CODE_W +: LEN_W];
  assign in_acc  = in_tvalid && in_tready;
  assign in_hit  = {1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT);
  assign in_idx  = in_sym[IDX_W-1:0];
  assign in_len_sat = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;

  // code table: code word and length per entry, valid flags in flops
  logic [CODE_W+LEN_W-1:0] tbl_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_vld_r;
  logic [CODE_W+LEN_W-1:0] rd_r;
  logic                    rd_vld_r;

  always_ff @(posedge clk) begin
    if (in_acc && in_hit && (op_t'(in_tuser) == OP_LOAD)) begin
      tbl_mem[in_idx] <= {in_code, in_len_sat};
    end
    if (in_acc && in_hit && (op_t'(in_tuser) == OP_ENCODE)) begin
      rd_r <= tbl_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (in_acc && in_hit && (op_t'(in_tuser) == OP_LOAD)) begin
        tbl_vld_r[in_idx] <= 1'b1;
      end
      if (in_acc && in_hit && (op_t'(in_tuser) == OP_ENCODE)) begin
        rd_vld_r <= tbl_vld_r[in_idx];
      end
    end
  end

  // packing stage: holds one encode or flush while the table read lands
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_enc_r, s1_enc_nxt;
  logic              s1_adv;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;

  logic [CODE_W-1:0] s1_code;
  logic [LEN_W-1:0]  s1_len;
  logic [CODE_W-1:0] s1_word;
  logic [ACC_W-1:0]  s1_acc;
  logic [LEN_W-1:0]  s1_total;
  logic [ALN_W-1:0]  s1_aln;
  logic [ECNT_W-1:0] s1_nbytes;
  logic [PCNT_W-1:0] s1_rest;

  assign s1_code = rd_r[LEN_W +: CODE_W];
  assign s1_len  = (s1_enc_r && rd_vld_r) ? rd_r[LEN_W-1:0] : '0;
  // only the low length bits of the word are appended
  assign s1_word = s1_code & ~({CODE_W{1'b1}} << s1_len);
  assign s1_acc  = ({{CODE_W{1'b0}}, pend_r} << s1_len) | {{PEND_W{1'b0}}, s1_word};
  assign s1_total = LEN_W'(pcnt_r) + s1_len;
  // left-align the valid bits so the bytes to emit sit at the top
  assign s1_aln  = {1'b0, s1_acc} << (LEN_W'(ALN_W) - s1_total);
  assign s1_rest = s1_total[PCNT_W-1:0];

  always_comb begin
    if (s1_enc_r) begin
      s1_nbytes = ECNT_W'(s1_total[LEN_W-1:PCNT_W]);
    end else begin
      s1_nbytes = (pcnt_r != '0) ? ECNT_W'(1) : '0;
    end
  end

  // byte register: shifts out one byte per handshake
  logic [EMIT_W-1:0] emit_r, emit_nxt;
  logic [ECNT_W-1:0] ecnt_r, ecnt_nxt;
  logic              emit_free;
  logic              out_acc;

  assign out_acc   = out_tvalid && out_tready;
  assign emit_free = (ecnt_r == '0) || ((ecnt_r == ECNT_W'(1)) && out_tready);
  assign s1_adv    = s1_vld_r && ((s1_nbytes == '0) || emit_free);
  assign in_tready = !s1_vld_r || s1_adv;

  assign out_tvalid = ecnt_r != '0;
  assign out_tdata  = emit_r[EMIT_W-1 -: BYTE_W];
  assign out_tlast  = ecnt_r == ECNT_W'(1);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    s1_enc_nxt = s1_enc_r;
    pend_nxt   = pend_r;
    pcnt_nxt   = pcnt_r;
    emit_nxt   = emit_r;
    ecnt_nxt   = ecnt_r;

    if (out_acc) begin
      emit_nxt = emit_r << BYTE_W;
      ecnt_nxt = ecnt_r - ECNT_W'(1);
    end

    if (s1_adv) begin
      s1_vld_nxt = 1'b0;
      if (s1_enc_r) begin
        pcnt_nxt = s1_rest;
        pend_nxt = s1_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << s1_rest);
      end else begin
        pcnt_nxt = '0;
        pend_nxt = '0;
      end
      if (s1_nbytes != '0) begin
        emit_nxt = s1_aln[ALN_W-1 -: EMIT_W];
        ecnt_nxt = s1_nbytes;
      end
    end

    // loads and unknown ops finish at accept; encodes out of the table do too
    if (in_acc) begin
      unique case (in_tuser)
        OP_ENCODE: begin
          s1_vld_nxt = in_hit;
          s1_enc_nxt = 1'b1;
        end
        OP_FLUSH: begin
          s1_vld_nxt = 1'b1;
          s1_enc_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      pend_r   <= '0;
      pcnt_r   <= '0;
      ecnt_r   <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
      ecnt_r   <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_enc_r <= s1_enc_nxt;
    emit_r   <= emit_nxt;
  end

endmodule

>>> rtl/core/hebp_checker.sv
module hebp_checker
  import hebp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // stalled byte holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // a run continues until its marked byte
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast && out_tready |=> out_tvalid)
    else $error("run ended without last byte");

  // no output appears without a recent request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_acc && !$past(in_acc) |=> !out_tvalid)
    else $error("output without request");

endmodule

bind huffman_encoder_bit_packer_core hebp_checker u_hebp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
